// ===== rtl/core/kntd_pkg.sv =====
// Shared definitions for the knob takeover dimmer: field widths, command
// codes, register indexes, reset values and the bundles passed between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kntd_pkg;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int KNOB_W  = 12;
  localparam int PCT_W   = 7;
  localparam int DUTY_W  = 12;
  localparam int THR_W   = 12;
  localparam int CNT_W   = 8;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;

  // Default PWM resolution
  localparam int PWM_BITS_DEF = 12;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOTE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT  = 1'b1;

  // Register reset values
  localparam logic [THR_W-1:0] THR_RESET  = 12'd200;
  localparam logic [CNT_W-1:0] CONF_RESET = 8'd3;

  // Scaling constants
  localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;
  localparam int                PCT_SCALE = 100;
  localparam int                PCT_ROUND = 50;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 8'd255;
  localparam logic [DUTY_W-1:0] DUTY_MAX  = 12'hFFF;

  // One input beat
  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [KNOB_W-1:0] knob_sample;
    logic              remote_knob_mode;
    logic              remote_power;
    logic [PCT_W-1:0]  remote_level;
  } item_t;

  // Lamp state after a command, handed to the scaling logic
  typedef struct packed {
    logic              mode_knob;
    logic              power;
    logic [KNOB_W-1:0] knob_value;
    logic [PCT_W-1:0]  remote_pct;
    logic              changed;
  } view_t;

endpackage

`default_nettype wire

// ===== rtl/core/kntd_takeover.sv =====
// Takeover state machine of the dimmer: holds mode, power, knob value, remote
// percent and the movement reference, and applies one command per advance.
// Depends on kntd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kntd_takeover #(
  parameter int PWM_BITS = kntd_pkg::PWM_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire kntd_pkg::item_t            item,
  input  wire logic [kntd_pkg::THR_W-1:0] move_threshold,
  input  wire logic [kntd_pkg::CNT_W-1:0] confirm_count,
  output kntd_pkg::view_t                 view
);
  import kntd_pkg::*;

  localparam int unsigned PWM_MAX  = (1 << PWM_BITS) - 1;
  localparam int unsigned KNOB_CAP = (PWM_MAX > 4095) ? 4095 : PWM_MAX;
  localparam logic [KNOB_W-1:0] KNOB_CAP_V = KNOB_CAP[KNOB_W-1:0];

  logic              mode_r,   mode_nxt;
  logic              power_r,  power_nxt;
  logic [KNOB_W-1:0] knob_r,   knob_nxt;
  logic [PCT_W-1:0]  rpct_r,   rpct_nxt;
  logic [KNOB_W-1:0] ref_r,    ref_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic              refv_r,   refv_nxt;
  logic              changed;

  logic [KNOB_W-1:0] sample_sat;
  logic [KNOB_W-1:0] diff;
  logic [CNT_W-1:0]  cnt_inc;

  // Clamp the sample to the PWM range, measure movement, advance the count
  assign sample_sat = (item.knob_sample > KNOB_CAP_V) ? KNOB_CAP_V : item.knob_sample;
  assign diff       = (sample_sat > ref_r) ? (sample_sat - ref_r) : (ref_r - sample_sat);
  assign cnt_inc    = (cnt_r == CNT_MAX) ? cnt_r : (cnt_r + 1'b1);

  // Apply the command
  always_comb begin
    mode_nxt  = mode_r;
    power_nxt = power_r;
    knob_nxt  = knob_r;
    rpct_nxt  = rpct_r;
    ref_nxt   = ref_r;
    cnt_nxt   = cnt_r;
    refv_nxt  = refv_r;
    changed   = 1'b0;
    case (item.command)
      CMD_SAMPLE: begin
        knob_nxt = sample_sat;
        if (!refv_r) begin
          // first sample only captures the reference
          ref_nxt  = sample_sat;
          refv_nxt = 1'b1;
        end else if (mode_r && power_r) begin
          // knob already in control: follow it
          ref_nxt = sample_sat;
          cnt_nxt = '0;
        end else if (diff < move_threshold) begin
          cnt_nxt = '0;
        end else if (cnt_inc < confirm_count) begin
          cnt_nxt = cnt_inc;
        end else begin
          // takeover confirmed
          cnt_nxt   = '0;
          ref_nxt   = sample_sat;
          mode_nxt  = 1'b1;
          power_nxt = 1'b1;
          changed   = 1'b1;
        end
      end
      CMD_TOUCH: begin
        power_nxt = !power_r;
        ref_nxt   = knob_r;
        cnt_nxt   = '0;
        changed   = 1'b1;
      end
      CMD_REMOTE: begin
        mode_nxt  = item.remote_knob_mode;
        power_nxt = item.remote_power;
        rpct_nxt  = (item.remote_level > PCT_MAX) ? PCT_MAX : item.remote_level;
        ref_nxt   = knob_r;
        cnt_nxt   = '0;
      end
      default: begin
        // unused code: leave everything as is
      end
    endcase
  end

  // Commit the new state when the beat retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      power_r <= 1'b0;
      knob_r  <= '0;
      rpct_r  <= '0;
      ref_r   <= '0;
      cnt_r   <= '0;
      refv_r  <= 1'b0;
    end else if (adv) begin
      mode_r  <= mode_nxt;
      power_r <= power_nxt;
      knob_r  <= knob_nxt;
      rpct_r  <= rpct_nxt;
      ref_r   <= ref_nxt;
      cnt_r   <= cnt_nxt;
      refv_r  <= refv_nxt;
    end
  end

  assign view.mode_knob  = mode_nxt;
  assign view.power      = power_nxt;
  assign view.knob_value = knob_nxt;
  assign view.remote_pct = rpct_nxt;
  assign view.changed    = changed;

endmodule

`default_nettype wire

// ===== rtl/core/kntd_scale.sv =====
// Output scaling of the dimmer: knob percent, remote duty and the lamp
// outputs, all by reciprocal multiplication with elaboration-time constants.
// Depends on kntd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kntd_scale #(
  parameter int PWM_BITS = kntd_pkg::PWM_BITS_DEF
) (
  input  wire kntd_pkg::view_t              view,
  output logic [kntd_pkg::DUTY_W-1:0]       duty,
  output logic [kntd_pkg::PCT_W-1:0]        shown_level,
  output logic [kntd_pkg::PCT_W-1:0]        knob_level
);
  import kntd_pkg::*;

  localparam int unsigned PWM_MAX = (1 << PWM_BITS) - 1;

  // knob percent = (knob * 100 + PWM_MAX / 2) / PWM_MAX, exact for the whole range
  localparam int S1   = 2 * PWM_BITS + 7;
  localparam int P1_W = S1 + 8;
  localparam logic [63:0] R1 = ((64'd1 << S1) + 64'(PWM_MAX) - 64'd1) / 64'(PWM_MAX);
  localparam logic [P1_W-1:0] C1 = P1_W'(R1 * 64'(PCT_SCALE));
  localparam logic [P1_W-1:0] C2 = P1_W'(R1 * 64'(PWM_MAX / 2));

  // remote duty = (percent * PWM_MAX + 50) / 100
  localparam int S2   = PWM_BITS + 14;
  localparam int P2_W = 2 * PWM_BITS + 15;
  localparam logic [63:0] R2 = ((64'd1 << S2) + 64'(PCT_SCALE) - 64'd1) / 64'(PCT_SCALE);
  localparam logic [P2_W-1:0] D1 = P2_W'(R2 * 64'(PWM_MAX));
  localparam logic [P2_W-1:0] D2 = P2_W'(R2 * 64'(PCT_ROUND));

  localparam int WIDE = (PWM_BITS > DUTY_W) ? PWM_BITS : DUTY_W;

  logic [P1_W-1:0]     pct_acc;
  logic [P2_W-1:0]     duty_acc;
  logic [PWM_BITS-1:0] rq;
  logic [WIDE-1:0]     rq_w;
  logic [DUTY_W-1:0]   duty_remote;

  // Knob percent
  assign pct_acc    = P1_W'(view.knob_value) * C1 + C2;
  assign knob_level = pct_acc[S1 +: PCT_W];

  // Remote duty, saturated to the duty field
  assign duty_acc    = P2_W'(view.remote_pct) * D1 + D2;
  assign rq          = duty_acc[S2 +: PWM_BITS];
  assign rq_w        = WIDE'(rq);
  assign duty_remote = (rq_w > WIDE'(DUTY_MAX)) ? DUTY_MAX : rq_w[DUTY_W-1:0];

  // Select by mode, zero when off
  always_comb begin
    duty        = '0;
    shown_level = '0;
    if (view.power) begin
      if (view.mode_knob) begin
        duty        = view.knob_value;
        shown_level = knob_level;
      end else begin
        duty        = duty_remote;
        shown_level = view.remote_pct;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/knob_takeover_dimmer.sv =====
// Knob takeover dimmer top level: input register, takeover state, scaling
// and result register. Depends on kntd_pkg, kntd_takeover and kntd_scale.
//
// Usage:
//   Input channel (in_*): one command per beat: knob sample, touch toggle or
//   remote update. Result channel (out_*): exactly one result beat per
//   command, showing duty, levels and mode after the command took effect.
//   Configuration (cfg_*): write move_threshold (index 0) or confirm_count
//   (index 1) with cfg_we while no beat is in flight.
// Timing:
//   A beat accepted into the input register passes the takeover logic and
//   the constant-reciprocal multipliers and is written to the result register
//   when it advances; a result held by out_stall can delay that advance.
//   One beat per cycle is sustained while out_stall is low, set by the single pass
//   between the input register and the result register.
// Reset: rst_n (synchronous) empties both registers, clears lamp state and
//   restores the register defaults (threshold 200, confirm count 3).
// Stall: while out_stall holds a result, the input register still takes one
//   more beat; in_stall rises only when both registers are full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module knob_takeover_dimmer #(
  parameter int PWM_BITS = kntd_pkg::PWM_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [kntd_pkg::CMD_W-1:0]     in_command,
  input  wire logic [kntd_pkg::KNOB_W-1:0]    in_knob_sample,
  input  wire logic                           in_remote_knob_mode,
  input  wire logic                           in_remote_power,
  input  wire logic [kntd_pkg::PCT_W-1:0]     in_remote_level,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [kntd_pkg::DUTY_W-1:0]         out_duty,
  output logic [kntd_pkg::PCT_W-1:0]          out_shown_level,
  output logic [kntd_pkg::PCT_W-1:0]          out_knob_level,
  output logic                                out_lamp_on,
  output logic                                out_knob_in_control,
  output logic                                out_settings_changed,
  // configuration
  input  wire logic                           cfg_we,
  input  wire logic [kntd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [kntd_pkg::CFG_W-1:0]     cfg_data
);
  import kntd_pkg::*;

  logic              s1_valid_r;
  item_t             s1_item_r;
  logic              s1_go;
  logic              in_acc;
  logic              out_valid_r;
  logic [THR_W-1:0]  move_thr_r;
  logic [CNT_W-1:0]  conf_cnt_r;

  view_t             view;
  logic [DUTY_W-1:0] duty;
  logic [PCT_W-1:0]  shown_level;
  logic [PCT_W-1:0]  knob_level;

  logic [DUTY_W-1:0] duty_r;
  logic [PCT_W-1:0]  shown_r;
  logic [PCT_W-1:0]  knob_lvl_r;
  logic              lamp_r;
  logic              knob_ctl_r;
  logic              changed_r;

  // Handshake: advance the held beat whenever the result register frees up
  assign s1_go    = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_thr_r <= THR_RESET;
      conf_cnt_r <= CONF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOVE_THRESHOLD: move_thr_r <= cfg_data[THR_W-1:0];
        REG_CONFIRM_COUNT:  conf_cnt_r <= cfg_data[CNT_W-1:0];
        default: begin
          // no other registers
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.command          <= in_command;
      s1_item_r.knob_sample      <= in_knob_sample;
      s1_item_r.remote_knob_mode <= in_remote_knob_mode;
      s1_item_r.remote_power     <= in_remote_power;
      s1_item_r.remote_level     <= in_remote_level;
    end
  end

  kntd_takeover #(
    .PWM_BITS (PWM_BITS)
  ) u_takeover (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (s1_go),
    .item           (s1_item_r),
    .move_threshold (move_thr_r),
    .confirm_count  (conf_cnt_r),
    .view           (view)
  );

  kntd_scale #(
    .PWM_BITS (PWM_BITS)
  ) u_scale (
    .view        (view),
    .duty        (duty),
    .shown_level (shown_level),
    .knob_level  (knob_level)
  );

  // Result register: fill on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      duty_r     <= duty;
      shown_r    <= shown_level;
      knob_lvl_r <= knob_level;
      lamp_r     <= view.power;
      knob_ctl_r <= view.mode_knob;
      changed_r  <= view.changed;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_duty             = duty_r;
  assign out_shown_level      = shown_r;
  assign out_knob_level       = knob_lvl_r;
  assign out_lamp_on          = lamp_r;
  assign out_knob_in_control  = knob_ctl_r;
  assign out_settings_changed = changed_r;

endmodule

`default_nettype wire

// ===== rtl/core/kntd_checker.sv =====
// Port-level checks for the knob takeover dimmer, bound to the top level.
// Depends on kntd_pkg and knob_takeover_dimmer.
`timescale 1ns / 1ps
`default_nettype none

module kntd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [kntd_pkg::DUTY_W-1:0]    out_duty,
  input wire logic [kntd_pkg::PCT_W-1:0]     out_shown_level,
  input wire logic [kntd_pkg::PCT_W-1:0]     out_knob_level,
  input wire logic                           out_lamp_on,
  input wire logic                           out_knob_in_control,
  input wire logic                           out_settings_changed
);
  import kntd_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty) &&
      $stable(out_shown_level) && $stable(out_settings_changed))
    else $error("stalled result beat changed");

  // Back-pressure only when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Lamp off shows nothing
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_lamp_on |-> out_duty == '0 && out_shown_level == '0)
    else $error("lamp off but duty or level nonzero");

  // Knob in control shows the knob percent
  a_knob_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lamp_on && out_knob_in_control |-> out_shown_level == out_knob_level)
    else $error("knob mode level mismatch");

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind knob_takeover_dimmer kntd_checker u_kntd_checker (.*);

`default_nettype wire
